>>> sv/c128b_pkg.sv
package c128b_pkg;

  localparam logic [7:0] FirstPrintable = 8'h20;
  localparam logic [7:0] LastPrintable  = 8'h7E;
  localparam logic [6:0] StartBValue    = 7'd104;
  localparam logic [6:0] StopValue      = 7'd106;
  localparam logic [7:0] CheckModulus   = 8'd103;
  localparam logic [6:0] StartCheck     = 7'd1;   // 104 mod 103
  localparam logic [1:0] StopTrailBar   = 2'd2;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Symbol slots within one queued word, in emission order.
  localparam int unsigned SlotStart = 0;
  localparam int unsigned SlotData  = 1;
  localparam int unsigned SlotCheck = 2;
  localparam int unsigned SlotStop  = 3;
  localparam int unsigned NumSlots  = 4;

  // Front pipeline register: one accepted character after classification.
  typedef struct packed {
    logic        start;
    logic        data;
    logic [6:0]  value;
    logic [12:0] prod;    // value times its position among the data symbols
    logic        last;
  } c128b_stage_t;

  // Queue word: every symbol one character causes.
  typedef struct packed {
    logic       start;
    logic       data;
    logic [6:0] value;
    logic [6:0] check;
    logic       last;
  } c128b_entry_t;

  // (h * 64) mod 103 for the upper bits of a 13-bit product.
  typedef logic [6:0] c128b_hi_tab_t [128];

  function automatic c128b_hi_tab_t build_hi_tab();
    c128b_hi_tab_t tab;
    for (int i = 0; i < 128; i++) begin
      tab[i] = 7'((i * 64) % 103);
    end
    return tab;
  endfunction

  localparam c128b_hi_tab_t HiModTab = build_hi_tab();

  // Element widths, first bar in the top octal digit, last space in the bottom.
  localparam logic [17:0] SymWidths [107] = '{
    18'o212222, 18'o222122, 18'o222221, 18'o121223, 18'o121322,
    18'o131222, 18'o122213, 18'o122312, 18'o132212, 18'o221213,
    18'o221312, 18'o231212, 18'o112232, 18'o122132, 18'o122231,
    18'o113222, 18'o123122, 18'o123221, 18'o223211, 18'o221132,
    18'o221231, 18'o213212, 18'o223112, 18'o312131, 18'o311222,
    18'o321122, 18'o321221, 18'o312212, 18'o322112, 18'o322211,
    18'o212123, 18'o212321, 18'o232121, 18'o111323, 18'o131123,
    18'o131321, 18'o112313, 18'o132113, 18'o132311, 18'o211313,
    18'o231113, 18'o231311, 18'o112133, 18'o112331, 18'o132131,
    18'o113123, 18'o113321, 18'o133121, 18'o313121, 18'o211331,
    18'o231131, 18'o213113, 18'o213311, 18'o213131, 18'o311123,
    18'o311321, 18'o331121, 18'o312113, 18'o312311, 18'o332111,
    18'o314111, 18'o221411, 18'o431111, 18'o111224, 18'o111422,
    18'o121124, 18'o121421, 18'o141122, 18'o141221, 18'o112214,
    18'o112412, 18'o122114, 18'o122411, 18'o142112, 18'o142211,
    18'o241211, 18'o221114, 18'o413111, 18'o241112, 18'o134111,
    18'o111242, 18'o121142, 18'o121241, 18'o114212, 18'o124112,
    18'o124211, 18'o411212, 18'o421112, 18'o421211, 18'o212141,
    18'o214121, 18'o412121, 18'o111143, 18'o111341, 18'o131141,
    18'o114113, 18'o114311, 18'o411113, 18'o411311, 18'o113141,
    18'o114131, 18'o311141, 18'o411131, 18'o211412, 18'o211214,
    18'o211232, 18'o233111
  };

endpackage

>>> sv/c128b_front.sv
module c128b_front
  import c128b_pkg::*;
#(
  parameter int unsigned MAX_DATA_SYMBOLS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   char_code_i,
  input  logic         end_of_text_i,
  input  logic         full_i,
  output logic         push_o,
  output c128b_entry_t push_entry_o
);

  localparam logic [5:0] MaxData = 6'(MAX_DATA_SYMBOLS);

  logic         open_q, open_d;
  logic [5:0]   count_q, count_d;
  logic         p1_valid_q, p1_valid_d;
  c128b_stage_t p1_q, p1_d;
  logic [6:0]   acc_q, acc_d;

  logic         accept;
  logic         advance;
  logic         printable;
  logic [5:0]   n_base;
  logic [5:0]   n_new;
  logic [6:0]   r_hi;
  logic [7:0]   r_sum;
  logic [6:0]   r_mod;
  logic [6:0]   acc_base;
  logic [7:0]   c_sum;
  logic [6:0]   c_mod;

  assign advance    = p1_valid_q && !full_i;
  assign in_ready_o = !p1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Stage 1: classify, track the position, form value times position.
  always_comb begin
    printable = (char_code_i >= FirstPrintable) && (char_code_i <= LastPrintable);
    n_base    = open_q ? count_q : 6'd0;
    n_new     = n_base + 6'd1;
    p1_d.start = !open_q;
    p1_d.data  = printable && (n_base < MaxData);
    p1_d.value = 7'(char_code_i - FirstPrintable);
    p1_d.prod  = 13'(p1_d.value) * 13'(n_new);
    p1_d.last  = end_of_text_i;

    open_d  = open_q;
    count_d = count_q;
    if (accept) begin
      open_d  = !end_of_text_i;
      count_d = end_of_text_i ? 6'd0 : (p1_d.data ? n_new : n_base);
    end

    p1_valid_d = p1_valid_q;
    if (accept) begin
      p1_valid_d = 1'b1;
    end else if (advance) begin
      p1_valid_d = 1'b0;
    end
  end

  // Stage 2: reduce the product mod 103 and fold it into the checksum.
  always_comb begin
    r_hi     = HiModTab[p1_q.prod[12:6]];
    r_sum    = {1'b0, r_hi} + {2'b00, p1_q.prod[5:0]};
    r_mod    = (r_sum >= CheckModulus) ? 7'(r_sum - CheckModulus) : r_sum[6:0];
    acc_base = p1_q.start ? StartCheck : acc_q;
    c_sum    = {1'b0, acc_base} + (p1_q.data ? {1'b0, r_mod} : 8'd0);
    c_mod    = (c_sum >= CheckModulus) ? 7'(c_sum - CheckModulus) : c_sum[6:0];

    acc_d = acc_q;
    if (advance) begin
      acc_d = p1_q.last ? 7'd0 : c_mod;
    end

    push_o             = advance;
    push_entry_o.start = p1_q.start;
    push_entry_o.data  = p1_q.data;
    push_entry_o.value = p1_q.value;
    push_entry_o.check = c_mod;
    push_entry_o.last  = p1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      count_q    <= 6'd0;
      p1_valid_q <= 1'b0;
      acc_q      <= 7'd0;
    end else begin
      open_q     <= open_d;
      count_q    <= count_d;
      p1_valid_q <= p1_valid_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q <= p1_d;
    end
  end

endmodule

>>> sv/c128b_queue.sv
module c128b_queue
  import c128b_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  c128b_entry_t push_entry_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output c128b_entry_t head_o
);

  c128b_entry_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> sv/c128b_back.sv
module c128b_back
  import c128b_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  c128b_entry_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [6:0]   symbol_value_o,
  output logic [17:0]  widths_o,
  output logic [1:0]   trailing_bar_o,
  output logic         message_done_o
);

  logic [NumSlots-1:0] done_q, done_d;
  logic                out_valid_q, out_valid_d;
  logic [6:0]          value_q, value_d;
  logic [17:0]         widths_q, widths_d;
  logic                stop_q, stop_d;

  logic [NumSlots-1:0] req;
  logic [NumSlots-1:0] pending;
  logic [NumSlots-1:0] sel;
  logic                can_load;
  logic                emit;

  always_comb begin
    req            = '0;
    req[SlotStart] = head_i.start;
    req[SlotData]  = head_i.data;
    req[SlotCheck] = head_i.last;
    req[SlotStop]  = head_i.last;
    pending        = req & ~done_q;
    // lowest pending slot goes out first
    sel            = pending & (~pending + 1'b1);
    can_load       = !out_valid_q || out_ready_i;
    emit           = !empty_i && can_load && (pending != '0);

    value_d = value_q;
    if (sel[SlotStart]) begin
      value_d = StartBValue;
    end else if (sel[SlotData]) begin
      value_d = head_i.value;
    end else if (sel[SlotCheck]) begin
      value_d = head_i.check;
    end else begin
      value_d = StopValue;
    end
    widths_d = SymWidths[value_d];
    stop_d   = sel[SlotStop];

    pop_o  = 1'b0;
    done_d = done_q;
    if (!empty_i && (pending == '0)) begin
      // character with nothing to show: drop it
      pop_o  = 1'b1;
      done_d = '0;
    end else if (emit) begin
      if ((pending & ~sel) == '0) begin
        pop_o  = 1'b1;
        done_d = '0;
      end else begin
        done_d = done_q | sel;
      end
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q  <= value_d;
      widths_q <= widths_d;
      stop_q   <= stop_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_value_o = value_q;
  assign widths_o       = widths_q;
  assign trailing_bar_o = stop_q ? StopTrailBar : 2'd0;
  assign message_done_o = stop_q;

endmodule

>>> sv/code128b_symbol_encoder_unit.sv
// Path to the master side: front register, then queue write, then output register.
// Throughput: one character per cycle on the slave side while the queue has room; one
//   symbol word per cycle on the master side while m_axis_tready is high, so Start B,
//   check and Stop words each take an output word of their own.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and queue and
//   closes any open message. No clearing pass is needed.
module code128b_symbol_encoder_unit
  import c128b_pkg::*;
#(
  parameter int unsigned MAX_DATA_SYMBOLS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] symbol_value, [9:7] bar_a, [12:10] space_a, [15:13] bar_b,
  // [18:16] space_b, [21:19] bar_c, [24:22] space_c, [26:25] trailing_bar,
  // [31:27] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast    // message_done
);

  // Front: classify each character, track position and checksum.
  // Queue: holds one word per character so each side stalls on its own.
  // Back: unroll each queued word into its symbols, one per cycle while the sink is ready.

  logic         push;
  c128b_entry_t push_entry;
  logic         full;
  logic         empty;
  logic         pop;
  c128b_entry_t head;
  logic [6:0]   symbol_value;
  logic [17:0]  widths;
  logic [1:0]   trailing_bar;

  c128b_front #(
    .MAX_DATA_SYMBOLS (MAX_DATA_SYMBOLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .char_code_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  c128b_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .empty_o      (empty),
    .head_o       (head)
  );

  c128b_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .symbol_value_o (symbol_value),
    .widths_o       (widths),
    .trailing_bar_o (trailing_bar),
    .message_done_o (m_axis_tlast)
  );

  // Widths table keeps the first bar in the top digit; pack bar_a into the low bits.
  assign m_axis_tdata = {5'd0, trailing_bar,
                         widths[2:0], widths[5:3], widths[8:6],
                         widths[11:9], widths[14:12], widths[17:15],
                         symbol_value};

endmodule

>>> sv/c128b_checker.sv
module c128b_checker
  import c128b_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_stop_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[6:0] == StopValue)
    else $error("message end not on Stop");

  a_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast && m_axis_tdata[26:25] == StopTrailBar)
      || (!m_axis_tlast && m_axis_tdata[26:25] == 2'd0))
    else $error("trailing bar does not match message end");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6:0] <= StopValue && m_axis_tdata[31:27] == 5'd0)
    else $error("symbol value out of range or padding set");

endmodule

bind code128b_symbol_encoder_unit c128b_checker u_c128b_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
